### rtl/core/mcfp_pkg.sv
package mcfp_pkg;

	// block dimensions
	localparam int CHANNELS        = 4;
	localparam int CH_AW           = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int MAX_FRAME_BYTES = 240;

	// frame header bytes
	localparam logic [7:0] HDR_FIRST  = 8'hFF;
	localparam logic [7:0] HDR_SECOND = 8'h55;

	// command table reset values
	localparam logic [7:0] E0_MODE_RST = 8'h01;
	localparam logic [7:0] E0_CMD_RST  = 8'h00;
	localparam logic [7:0] E1_MODE_RST = 8'h01;
	localparam logic [7:0] E1_CMD_RST  = 8'hF0;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_E0_MODE    = 3'd0,
		CFG_E0_COMMAND = 3'd1,
		CFG_E0_PAYLOAD = 3'd2,
		CFG_E1_MODE    = 3'd3,
		CFG_E1_COMMAND = 3'd4,
		CFG_E1_PAYLOAD = 3'd5
	} cfg_idx_t;

	// per-channel parse phase
	typedef enum logic [2:0] {
		PH_HEAD1 = 3'd0,
		PH_HEAD2 = 3'd1,
		PH_LEN   = 3'd2,
		PH_INDEX = 3'd3,
		PH_MODE  = 3'd4,
		PH_CMD   = 3'd5,
		PH_DATA  = 3'd6
	} phase_t;

	// per-channel frame context held in the context memory
	typedef struct packed {
		phase_t     phase;
		logic [7:0] declared_length;
		logic [7:0] counted_bytes;
		logic [7:0] held_index;
		logic [7:0] held_mode;
		logic [7:0] held_command;
	} ctx_t;

	// command table
	typedef struct packed {
		logic [7:0] e0_mode;
		logic [7:0] e0_command;
		logic       e0_has_payload;
		logic [7:0] e1_mode;
		logic [7:0] e1_command;
		logic       e1_has_payload;
	} cfg_t;

	typedef struct packed {
		logic [1:0] channel;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0] out_channel;
		logic       kind;
		logic       entry_hit;
		logic [7:0] frame_index;
		logic [7:0] frame_mode;
		logic [7:0] frame_command;
		logic [7:0] payload_value;
		logic [7:0] byte_count;
	} out_item_t;

	// channel number to context memory address
	function automatic logic [CH_AW-1:0] ch_addr(input logic [1:0] c);
		logic [CH_AW+1:0] w;
		w = {{CH_AW{1'b0}}, c};
		return w[CH_AW-1:0];
	endfunction

endpackage

### rtl/core/multichannel_command_frame_parser.sv
// result path: each byte goes through the registered context read, then the output register
// throughput: one byte per cycle, any mix of channels, unless a blocked output stalls the input
// back-to-back on one channel too, via the context memory read-modify-write with write forwarding
// reset: all channels await the first header at once (per-entry written flags), table to defaults
// bytes that produce no result still take one pass through the context stage
module multichannel_command_frame_parser
	import mcfp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data,
	input  logic      cfg_we,
	input  logic [2:0] cfg_addr,
	input  logic [7:0] cfg_wdata
);

	cfg_t       cfg_q;
	logic       in_fire;
	logic       in_range;
	logic       s1_valid;
	logic       s1_inrange;
	logic [1:0] s1_channel;
	logic [7:0] s1_byte;
	logic       s1_fire;
	logic       out_free;
	logic       out_valid_q;
	out_item_t  out_data_q;
	ctx_t       cur_ctx;
	ctx_t       nxt_ctx;
	logic       emit;
	out_item_t  res;

	// command table registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.e0_mode        <= E0_MODE_RST;
			cfg_q.e0_command     <= E0_CMD_RST;
			cfg_q.e0_has_payload <= 1'b0;
			cfg_q.e1_mode        <= E1_MODE_RST;
			cfg_q.e1_command     <= E1_CMD_RST;
			cfg_q.e1_has_payload <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_addr))
				CFG_E0_MODE:    cfg_q.e0_mode        <= cfg_wdata;
				CFG_E0_COMMAND: cfg_q.e0_command     <= cfg_wdata;
				CFG_E0_PAYLOAD: cfg_q.e0_has_payload <= cfg_wdata[0];
				CFG_E1_MODE:    cfg_q.e1_mode        <= cfg_wdata;
				CFG_E1_COMMAND: cfg_q.e1_command     <= cfg_wdata;
				CFG_E1_PAYLOAD: cfg_q.e1_has_payload <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// handshake
	assign out_free = !out_valid_q || out_ready;
	assign s1_fire  = s1_valid && out_free;
	assign in_ready = !s1_valid || s1_fire;
	assign in_fire  = in_valid && in_ready;
	assign in_range = 32'(in_data.channel) < CHANNELS;

	// context stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_fire) begin
			s1_valid <= 1'b1;
		end else if (s1_fire) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			s1_inrange <= in_range;
			s1_channel <= in_data.channel;
			s1_byte    <= in_data.rx_byte;
		end
	end

	mcfp_ctx_ram u_ctx_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_fire && in_range),
		.rd_addr (ch_addr(in_data.channel)),
		.wr_en   (s1_fire && s1_inrange),
		.wr_addr (ch_addr(s1_channel)),
		.wr_data (nxt_ctx),
		.rd_data (cur_ctx)
	);

	mcfp_step u_step (
		.cur     (cur_ctx),
		.channel (s1_channel),
		.rx_byte (s1_byte),
		.cfg     (cfg_q),
		.nxt     (nxt_ctx),
		.emit    (emit),
		.res     (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire) begin
			out_valid_q <= emit && s1_inrange;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTHESIS
	a_no_result_out_of_range: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && !s1_inrange) |=> !out_valid)
		else $error("result from out-of-range channel");
	a_dispatch_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.kind) |-> (out_data.payload_value == 8'd0))
		else $error("dispatch carries payload value");
	a_payload_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.kind) |-> (out_data.byte_count < 8'(MAX_FRAME_BYTES)))
		else $error("payload transfer at or beyond byte limit");
	a_stall_only_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (s1_valid && out_valid_q && !out_ready))
		else $error("input stalled without a blocked result");
`endif

endmodule

### rtl/core/mcfp_ctx_ram.sv
module mcfp_ctx_ram
	import mcfp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [CH_AW-1:0] rd_addr,
	input  logic             wr_en,
	input  logic [CH_AW-1:0] wr_addr,
	input  ctx_t             wr_data,
	output ctx_t             rd_data
);

	ctx_t             mem [CHANNELS];
	logic [CHANNELS-1:0] vld_q;
	ctx_t             rdata_q;
	logic             rvld_q;
	logic             fwd_q;
	ctx_t             fwd_data_q;

	// context storage, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q    <= mem[rd_addr];
			fwd_data_q <= wr_data;
		end
	end

	// written flags, an unwritten entry reads as the reset context
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
			fwd_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rvld_q <= vld_q[rd_addr];
				fwd_q  <= wr_en && (wr_addr == rd_addr);
			end
		end
	end

	// forward a write that lands on the same edge as the read
	always_comb begin
		if (fwd_q) begin
			rd_data = fwd_data_q;
		end else if (rvld_q) begin
			rd_data = rdata_q;
		end else begin
			rd_data = ctx_t'('0);
		end
	end

endmodule

### rtl/core/mcfp_step.sv
module mcfp_step
	import mcfp_pkg::*;
(
	input  ctx_t       cur,
	input  logic [1:0] channel,
	input  logic [7:0] rx_byte,
	input  cfg_t       cfg,
	output ctx_t       nxt,
	output logic       emit,
	output out_item_t  res
);

	logic [7:0] cmd_sel;
	logic       hit0;
	logic       hit1;
	logic       hit;
	logic       has_payload;
	logic [7:0] cnt_inc;
	logic       is_payload;

	// table lookup, entry zero wins
	always_comb begin
		cmd_sel     = (cur.phase == PH_CMD) ? rx_byte : cur.held_command;
		hit0        = (cur.held_mode == cfg.e0_mode) && (cmd_sel == cfg.e0_command);
		hit1        = (cur.held_mode == cfg.e1_mode) && (cmd_sel == cfg.e1_command);
		hit         = hit0 || hit1;
		has_payload = hit0 ? cfg.e0_has_payload : cfg.e1_has_payload;
		cnt_inc     = cur.counted_bytes + 8'd1;
	end

	// phase sequencing
	always_comb begin
		nxt        = cur;
		emit       = 1'b0;
		is_payload = 1'b0;
		unique case (cur.phase)
			PH_HEAD2: begin
				if (rx_byte == HDR_SECOND) begin
					nxt.phase = PH_LEN;
				end
			end
			PH_LEN: begin
				nxt.declared_length = rx_byte;
				nxt.counted_bytes   = 8'd0;
				nxt.phase           = PH_INDEX;
			end
			PH_INDEX: begin
				nxt.held_index    = rx_byte;
				nxt.counted_bytes = 8'd1;
				nxt.phase         = PH_MODE;
			end
			PH_MODE: begin
				nxt.held_mode     = rx_byte;
				nxt.counted_bytes = 8'd2;
				nxt.phase         = PH_CMD;
			end
			PH_CMD: begin
				nxt.held_command  = rx_byte;
				nxt.counted_bytes = 8'd3;
				if (hit && has_payload) begin
					nxt.phase = PH_DATA;
				end else begin
					nxt.phase = PH_HEAD1;
					emit      = hit;
				end
			end
			PH_DATA: begin
				nxt.counted_bytes = cnt_inc;
				if (cnt_inc == cur.declared_length) begin
					nxt.phase = PH_HEAD1;
					emit      = hit;
				end else if (cnt_inc >= 8'(MAX_FRAME_BYTES)) begin
					nxt.phase = PH_HEAD1;
				end else begin
					emit       = 1'b1;
					is_payload = 1'b1;
				end
			end
			default: begin
				nxt.phase = (rx_byte == HDR_FIRST) ? PH_HEAD2 : PH_HEAD1;
			end
		endcase
	end

	// result fields from the updated context
	always_comb begin
		res.out_channel   = channel;
		res.kind          = !is_payload;
		res.entry_hit     = !hit0 && hit1;
		res.frame_index   = nxt.held_index;
		res.frame_mode    = nxt.held_mode;
		res.frame_command = nxt.held_command;
		res.payload_value = is_payload ? rx_byte : 8'd0;
		res.byte_count    = nxt.counted_bytes;
	end

endmodule

### tb/multichannel_command_frame_parser_test.sv
`timescale 1ns / 1ps

import mcfp_pkg::*;

localparam logic KIND_PAYLOAD  = 1'b0;
localparam logic KIND_DISPATCH = 1'b1;
localparam int   NO_ENTRY      = -1;

// tracks per-channel frame context and the results it should produce
class frame_result_tracker;
	cfg_t       tbl;
	phase_t     ch_phase   [CHANNELS];
	logic [7:0] ch_length  [CHANNELS];
	logic [7:0] ch_count   [CHANNELS];
	logic [7:0] ch_index   [CHANNELS];
	logic [7:0] ch_mode    [CHANNELS];
	logic [7:0] ch_command [CHANNELS];
	out_item_t  due_results[$];
	int         mismatches;

	function new();
		tbl.e0_mode        = E0_MODE_RST;
		tbl.e0_command     = E0_CMD_RST;
		tbl.e0_has_payload = 1'b0;
		tbl.e1_mode        = E1_MODE_RST;
		tbl.e1_command     = E1_CMD_RST;
		tbl.e1_has_payload = 1'b0;
		for (int c = 0; c < CHANNELS; c++) begin
			ch_phase[c]   = PH_HEAD1;
			ch_length[c]  = '0;
			ch_count[c]   = '0;
			ch_index[c]   = '0;
			ch_mode[c]    = '0;
			ch_command[c] = '0;
		end
		mismatches = 0;
	endfunction

	function void set_reg(cfg_idx_t idx, logic [7:0] v);
		case (idx)
			CFG_E0_MODE:    tbl.e0_mode        = v;
			CFG_E0_COMMAND: tbl.e0_command     = v;
			CFG_E0_PAYLOAD: tbl.e0_has_payload = v[0];
			CFG_E1_MODE:    tbl.e1_mode        = v;
			CFG_E1_COMMAND: tbl.e1_command     = v;
			CFG_E1_PAYLOAD: tbl.e1_has_payload = v[0];
			default: ;
		endcase
	endfunction

	// entry zero takes priority when both match
	function int match_entry(logic [7:0] m, logic [7:0] cm);
		if (m == tbl.e0_mode && cm == tbl.e0_command)
			return 0;
		if (m == tbl.e1_mode && cm == tbl.e1_command)
			return 1;
		return NO_ENTRY;
	endfunction

	function logic entry_has_payload(int hit);
		return (hit == 0) ? tbl.e0_has_payload : tbl.e1_has_payload;
	endfunction

	function void queue_result(int c, logic kind, int hit, logic [7:0] b);
		out_item_t r;
		r.out_channel   = 2'(c);
		r.kind          = kind;
		r.entry_hit     = (hit > 0);
		r.frame_index   = ch_index[c];
		r.frame_mode    = ch_mode[c];
		r.frame_command = ch_command[c];
		r.payload_value = (kind == KIND_DISPATCH) ? 8'h00 : b;
		r.byte_count    = ch_count[c];
		due_results.push_back(r);
	endfunction

	// advance one channel's parse on an accepted byte
	function void note_byte(in_item_t it);
		int         c;
		int         hit;
		logic [7:0] b;
		c = int'(it.channel);
		b = it.rx_byte;
		if (c >= CHANNELS)
			return;
		case (ch_phase[c])
			PH_HEAD2: begin
				if (b == HDR_SECOND)
					ch_phase[c] = PH_LEN;
			end
			PH_LEN: begin
				ch_length[c] = b;
				ch_count[c]  = 8'd0;
				ch_phase[c]  = PH_INDEX;
			end
			PH_INDEX: begin
				ch_index[c] = b;
				ch_count[c] = 8'd1;
				ch_phase[c] = PH_MODE;
			end
			PH_MODE: begin
				ch_mode[c]  = b;
				ch_count[c] = 8'd2;
				ch_phase[c] = PH_CMD;
			end
			PH_CMD: begin
				ch_command[c] = b;
				ch_count[c]   = 8'd3;
				hit = match_entry(ch_mode[c], b);
				if (hit == NO_ENTRY) begin
					ch_phase[c] = PH_HEAD1;
				end else if (entry_has_payload(hit)) begin
					ch_phase[c] = PH_DATA;
				end else begin
					ch_phase[c] = PH_HEAD1;
					queue_result(c, KIND_DISPATCH, hit, 8'h00);
				end
			end
			PH_DATA: begin
				ch_count[c] = ch_count[c] + 8'd1;
				hit = match_entry(ch_mode[c], ch_command[c]);
				if (ch_count[c] == ch_length[c]) begin
					ch_phase[c] = PH_HEAD1;
					if (hit != NO_ENTRY)
						queue_result(c, KIND_DISPATCH, hit, 8'h00);
				end else if (int'(ch_count[c]) >= MAX_FRAME_BYTES) begin
					ch_phase[c] = PH_HEAD1;
				end else begin
					queue_result(c, KIND_PAYLOAD, hit, b);
				end
			end
			default: begin
				ch_phase[c] = (b == HDR_FIRST) ? PH_HEAD2 : PH_HEAD1;
			end
		endcase
	endfunction

	function void compare_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	function void check_result(out_item_t got);
		out_item_t want;
		if (due_results.size() == 0) begin
			$display("%0t unexpected result: expected none actual %h", $time, got);
			mismatches++;
			return;
		end
		want = due_results.pop_front();
		compare_field("out_channel", want.out_channel, got.out_channel);
		compare_field("kind", want.kind, got.kind);
		compare_field("entry_hit", want.entry_hit, got.entry_hit);
		compare_field("frame_index", want.frame_index, got.frame_index);
		compare_field("frame_mode", want.frame_mode, got.frame_mode);
		compare_field("frame_command", want.frame_command, got.frame_command);
		compare_field("payload_value", want.payload_value, got.payload_value);
		compare_field("byte_count", want.byte_count, got.byte_count);
	endfunction
endclass

module multichannel_command_frame_parser_test;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;
	logic      cfg_we;
	logic [2:0] cfg_addr;
	logic [7:0] cfg_wdata;

	frame_result_tracker sb;
	logic [7:0]          pending_bytes [CHANNELS][$];
	bit                  idle_on;
	bit                  hold_req;

	multichannel_command_frame_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	// watch input and output for transfers
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_byte(in_data);
			if (out_valid && out_ready)
				sb.check_result(out_data);
		end
	end

	// receiver: random stalls, one long hold-off on request
	initial begin
		int n;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (80) @(negedge clk);
				hold_req = 1'b0;
				out_ready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 8);
				out_ready <= 1'b0;
				repeat (n) @(negedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// offer one byte, with an occasional gap before it
	task automatic push_byte(input int c, input logic [7:0] b);
		in_item_t it;
		int       gap;
		it.channel = 2'(c);
		it.rx_byte = b;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 8);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic flush_channel(input int c);
		while (pending_bytes[c].size() > 0)
			push_byte(c, pending_bytes[c].pop_front());
	endtask

	// stop offering and let every outstanding result arrive
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.due_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [7:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= v;
		sb.set_reg(idx, v);
	endtask

	task automatic set_table(input logic [7:0] m0, input logic [7:0] c0, input logic p0,
			input logic [7:0] m1, input logic [7:0] c1, input logic p1);
		write_reg(CFG_E0_MODE, m0);
		write_reg(CFG_E0_COMMAND, c0);
		write_reg(CFG_E0_PAYLOAD, {7'd0, p0});
		write_reg(CFG_E1_MODE, m1);
		write_reg(CFG_E1_COMMAND, c1);
		write_reg(CFG_E1_PAYLOAD, {7'd0, p1});
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// queue the next frame for a channel: mostly well formed, some noise and truncation
	function automatic void build_frame(int c);
		int         r;
		int         sel;
		int         hit;
		int         n;
		logic [7:0] m;
		logic [7:0] cm;
		logic [7:0] len;
		logic [7:0] junk;
		r = $urandom_range(0, 99);
		if (r < 80) begin
			pending_bytes[c].push_back(HDR_FIRST);
			if ($urandom_range(0, 7) == 0) begin
				n = $urandom_range(1, 2);
				repeat (n) begin
					junk = 8'($urandom_range(0, 255));
					if (junk == HDR_SECOND)
						junk = 8'h00;
					pending_bytes[c].push_back(junk);
				end
			end
			pending_bytes[c].push_back(HDR_SECOND);
			sel = $urandom_range(0, 9);
			if (sel < 4) begin
				m  = sb.tbl.e0_mode;
				cm = sb.tbl.e0_command;
			end else if (sel < 7) begin
				m  = sb.tbl.e1_mode;
				cm = sb.tbl.e1_command;
			end else begin
				m  = 8'($urandom_range(0, 255));
				cm = 8'($urandom_range(0, 255));
			end
			hit = sb.match_entry(m, cm);
			if (hit != NO_ENTRY && sb.entry_has_payload(hit)) begin
				// rare lengths that run into the byte limit or land right on it
				if ($urandom_range(0, 99) == 0)
					len = $urandom_range(0, 1) ? 8'($urandom_range(0, 3))
						: 8'($urandom_range(240, 255));
				else
					len = 8'($urandom_range(4, 14));
			end else begin
				len = 8'($urandom_range(0, 255));
			end
			pending_bytes[c].push_back(len);
			pending_bytes[c].push_back(8'($urandom_range(0, 255)));
			pending_bytes[c].push_back(m);
			pending_bytes[c].push_back(cm);
			if (hit != NO_ENTRY && sb.entry_has_payload(hit)) begin
				n = (len >= 8'd4 && int'(len) <= MAX_FRAME_BYTES) ? int'(len) - 3 : 237;
				repeat (n) pending_bytes[c].push_back(8'($urandom_range(0, 255)));
			end
		end else if (r < 90) begin
			n = $urandom_range(1, 6);
			repeat (n) pending_bytes[c].push_back(8'($urandom_range(0, 255)));
		end else begin
			n = $urandom_range(1, 4);
			pending_bytes[c].push_back(HDR_FIRST);
			if (n > 1) pending_bytes[c].push_back(HDR_SECOND);
			if (n > 2) pending_bytes[c].push_back(8'($urandom_range(0, 255)));
			if (n > 3) pending_bytes[c].push_back(8'($urandom_range(0, 255)));
		end
	endfunction

	// random traffic interleaved over all channels
	task automatic run_traffic(input int count);
		int c;
		for (int i = 0; i < count; i++) begin
			c = $urandom_range(0, CHANNELS - 1);
			if (pending_bytes[c].size() == 0)
				build_frame(c);
			push_byte(c, pending_bytes[c].pop_front());
		end
	endtask

	// main sequence
	initial begin
		in_valid  = 1'b0;
		in_data   = '0;
		out_ready = 1'b0;
		cfg_we    = 1'b0;
		cfg_addr  = '0;
		cfg_wdata = '0;
		idle_on   = 1'b1;
		hold_req  = 1'b0;
		arst_n    = 1'b0;
		sb = new();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// default table: dispatch on each entry, junk before the second header, unknown commands
		pending_bytes[0] = '{8'hFF, 8'h55, 8'h05, 8'h10, 8'h01, 8'h00};
		flush_channel(0);
		pending_bytes[1] = '{8'hFF, 8'h22, 8'hFF, 8'h55, 8'h03, 8'hAB, 8'h01, 8'hF0};
		flush_channel(1);
		pending_bytes[2] = '{8'hFF, 8'h55, 8'h04, 8'h00, 8'h01, 8'h77};
		flush_channel(2);
		pending_bytes[3] = '{8'hFF, 8'h55, 8'h00, 8'hFF, 8'hFF, 8'hFF};
		flush_channel(3);
		drain();

		// payload frame, completing byte not passed out; channel 3 left mid-payload
		set_table(8'h01, 8'h00, 1'b1, 8'h01, 8'hF0, 1'b0);
		pending_bytes[0] = '{8'hFF, 8'h55, 8'h06, 8'h01, 8'h01, 8'h00, 8'hAA, 8'h55, 8'h33};
		flush_channel(0);
		pending_bytes[3] = '{8'hFF, 8'h55, 8'h08, 8'h05, 8'h01, 8'h00, 8'h11};
		flush_channel(3);
		drain();

		// extremes of the table, with one long receiver hold-off
		set_table(8'h00, 8'h00, 1'b1, 8'hFF, 8'hFF, 1'b1);
		run_traffic(100);
		hold_req = 1'b1;
		run_traffic(220);
		drain();

		// both entries identical: entry zero wins
		set_table(8'h80, 8'h7F, 1'b1, 8'h80, 8'h7F, 1'b0);
		run_traffic(320);
		drain();

		set_table(8'hFF, 8'hFF, 1'b0, 8'h00, 8'h00, 1'b1);
		run_traffic(320);
		drain();

		set_table(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		run_traffic(320);
		drain();

		set_table(8'h01, 8'h00, 1'b1, 8'h01, 8'hF0, 1'b1);
		run_traffic(300);
		drain();

		// closing stretch at full rate on the default table
		idle_on = 1'b0;
		set_table(E0_MODE_RST, E0_CMD_RST, 1'b0, E1_MODE_RST, E1_CMD_RST, 1'b0);
		run_traffic(300);
		drain();

		if (sb.mismatches == 0 && sb.due_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
